/* rtl/mcrqb_pkg.sv */
package mcrqb_pkg;
    localparam int NUM_CPUS  = 4;
    localparam int NUM_TASKS = 64;
    localparam int CPU_W     = $clog2(NUM_CPUS);
    localparam int SLOT_W    = $clog2(NUM_TASKS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int REQ_W     = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_MAKE_READY = 3'd0,
        REQ_ENQ_LOCAL  = 3'd1,
        REQ_PICK_NEXT  = 3'd2,
        REQ_REMOVE     = 3'd3,
        REQ_NOT_READY  = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HOME,
        S_RM_RD,
        S_RM_ST,
        S_PK_RD,
        S_PK_ST,
        S_EMIT
    } t_state;
endpackage

/* rtl/multi_cpu_run_queue_balancer_unit.sv */
// make_ready, enqueue_local and mark_not_ready: executed in S_EXEC, then the result is loaded in S_EMIT
// pick_next: each popped queue entry takes a link memory read, then a pop
// remove: each entry walked in the home queue takes a link memory read, then a compare
// throughput: one request at a time, next accepted once the result is loaded
// reset: synchronous active low, clears flags, queue counts, rotate pointer and handshake
// link and home memories are not cleared; only entries inside a queue's count are read
module multi_cpu_run_queue_balancer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // req_type[2:0], task_slot[8:3], cpu[10:9]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // result_task[5:0], result_cpu[7:6], done_res[8], stolen[9]
);
    import mcrqb_pkg::*;

    logic [SLOT_W-1:0] link_mem [NUM_TASKS];
    logic [CPU_W-1:0]  home_mem [NUM_TASKS];

    t_state r_state, n_state;
    logic [REQ_W-1:0]  r_req;
    logic [SLOT_W-1:0] r_t;
    logic [CPU_W-1:0]  r_c;
    logic [NUM_TASKS-1:0] r_queued, n_queued, r_ready, n_ready;
    logic [SLOT_W-1:0] r_head [NUM_CPUS];
    logic [SLOT_W-1:0] n_head [NUM_CPUS];
    logic [SLOT_W-1:0] r_tail [NUM_CPUS];
    logic [SLOT_W-1:0] n_tail [NUM_CPUS];
    logic [CNT_W-1:0]  r_count [NUM_CPUS];
    logic [CNT_W-1:0]  n_count [NUM_CPUS];
    logic [CPU_W-1:0]  r_rot, n_rot;
    logic [CPU_W-1:0]  r_qc, n_qc;
    logic              r_steal, n_steal;
    logic [SLOT_W-1:0] r_cur, n_cur, r_prev, n_prev;
    logic              r_have_prev, n_have_prev;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [SLOT_W-1:0] r_res_task, n_res_task;
    logic [CPU_W-1:0]  r_res_cpu, n_res_cpu;
    logic              r_res_done, n_res_done, r_res_stl, n_res_stl;
    logic              r_ovalid, n_ovalid;
    logic [9:0]        r_odata, n_odata;

    logic [SLOT_W-1:0] r_link_rd, link_ra, link_wa, link_wd, home_wa;
    logic [CPU_W-1:0]  r_home_rd, home_wd;
    logic              link_we, home_we;

    logic [CPU_W-1:0]  best, busiest, e_cpu, rc;
    logic [CNT_W-1:0]  load;
    logic [SLOT_W-1:0] pt;

    always_comb begin
        best = r_rot;
        load = r_count[r_rot];
        for (int k = 1; k < NUM_CPUS; k++) begin
            rc = r_rot + CPU_W'(k);
            if (r_count[rc] < load) begin
                best = rc;
                load = r_count[rc];
            end
        end
        busiest = r_c;
        for (int k = 0; k < NUM_CPUS; k++) begin
            if (r_count[k] > r_count[busiest]) begin
                busiest = CPU_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_link_rd <= link_mem[link_ra];
        if (home_we) begin
            home_mem[home_wa] <= home_wd;
        end
        r_home_rd <= home_mem[r_t];
    end

    always_comb begin
        n_state     = r_state;
        n_queued    = r_queued;
        n_ready     = r_ready;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_rot       = r_rot;
        n_qc        = r_qc;
        n_steal     = r_steal;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_n         = r_n;
        n_res_task  = r_res_task;
        n_res_cpu   = r_res_cpu;
        n_res_done  = r_res_done;
        n_res_stl   = r_res_stl;
        n_ovalid    = r_ovalid;
        n_odata     = r_odata;
        link_we     = 1'b0;
        link_wa     = r_cur;
        link_wd     = r_t;
        link_ra     = r_cur;
        home_we     = 1'b0;
        home_wa     = r_t;
        home_wd     = r_c;
        e_cpu       = (r_req == REQ_MAKE_READY) ? best : r_c;
        pt          = r_head[r_qc];

        if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_task = '0;
                n_res_cpu  = '0;
                n_res_done = 1'b0;
                n_res_stl  = 1'b0;
                n_state    = S_EMIT;
                case (r_req)
                    REQ_MAKE_READY, REQ_ENQ_LOCAL: begin
                        if (r_req == REQ_ENQ_LOCAL) begin
                            n_res_cpu = r_c;
                        end else if (r_t >= SLOT_W'(NUM_CPUS)) begin
                            n_ready[r_t] = 1'b1;
                            n_res_cpu    = best;
                            n_rot        = best + CPU_W'(1);
                        end
                        if (r_t >= SLOT_W'(NUM_CPUS) && !r_queued[r_t]) begin
                            home_we         = 1'b1;
                            home_wd         = e_cpu;
                            n_queued[r_t]   = 1'b1;
                            if (r_count[e_cpu] == '0) begin
                                n_head[e_cpu] = r_t;
                            end else begin
                                link_we = 1'b1;
                                link_wa = r_tail[e_cpu];
                            end
                            n_tail[e_cpu]  = r_t;
                            n_count[e_cpu] = r_count[e_cpu] + CNT_W'(1);
                            n_res_done     = 1'b1;
                        end
                    end
                    REQ_PICK_NEXT: begin
                        n_res_task = SLOT_W'(r_c);
                        n_res_cpu  = r_c;
                        n_qc       = r_c;
                        n_steal    = 1'b0;
                        n_state    = S_PK_RD;
                    end
                    REQ_REMOVE: begin
                        n_ready[r_t] = 1'b0;
                        if (r_queued[r_t]) begin
                            n_state = S_HOME;
                        end
                    end
                    REQ_NOT_READY: begin
                        n_ready[r_t] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_HOME: begin
                n_res_cpu   = r_home_rd;
                n_qc        = r_home_rd;
                n_cur       = r_head[r_home_rd];
                n_n         = '0;
                n_have_prev = 1'b0;
                n_prev      = '0;
                n_state     = S_RM_RD;
            end
            S_RM_RD: begin
                if (r_n == r_count[r_qc]) begin
                    n_queued[r_t] = 1'b0;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_RM_ST;
                end
            end
            S_RM_ST: begin
                if (r_cur == r_t) begin
                    if (r_have_prev) begin
                        link_we = 1'b1;
                        link_wa = r_prev;
                        link_wd = r_link_rd;
                    end else begin
                        n_head[r_qc] = r_link_rd;
                    end
                    if (r_n + CNT_W'(1) == r_count[r_qc]) begin
                        n_tail[r_qc] = r_prev;
                    end
                    n_queued[r_t] = 1'b0;
                    n_count[r_qc] = r_count[r_qc] - CNT_W'(1);
                    n_res_done    = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_cur       = r_link_rd;
                    n_n         = r_n + CNT_W'(1);
                    n_state     = S_RM_RD;
                end
            end
            S_PK_RD: begin
                link_ra = pt;
                if (r_count[r_qc] == '0) begin
                    if (!r_steal && busiest != r_c && r_count[busiest] != '0) begin
                        n_qc    = busiest;
                        n_steal = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_PK_ST;
                end
            end
            S_PK_ST: begin
                n_count[r_qc] = r_count[r_qc] - CNT_W'(1);
                n_head[r_qc]  = r_link_rd;
                n_queued[pt]  = 1'b0;
                n_state       = S_PK_RD;
                if (r_ready[pt]) begin
                    n_res_task = pt;
                    n_res_done = 1'b1;
                    n_state    = S_EMIT;
                    if (r_steal) begin
                        n_res_cpu = r_qc;
                        n_res_stl = 1'b1;
                        home_we   = 1'b1;
                        home_wa   = pt;
                    end
                end
            end
            S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_res_stl, r_res_done, r_res_cpu, r_res_task};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_queued <= '0;
            r_ready  <= '0;
            r_rot    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NUM_CPUS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_queued <= n_queued;
            r_ready  <= n_ready;
            r_rot    <= n_rot;
            r_ovalid <= n_ovalid;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_req <= s_axis_tdata[2:0];
            r_t   <= s_axis_tdata[8:3];
            r_c   <= s_axis_tdata[10:9];
        end
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_qc        <= n_qc;
        r_steal     <= n_steal;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_n         <= n_n;
        r_res_task  <= n_res_task;
        r_res_cpu   <= n_res_cpu;
        r_res_done  <= n_res_done;
        r_res_stl   <= n_res_stl;
        r_odata     <= n_odata;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata};
endmodule
